FILE: rtl/core/tpt_pkg.sv
package tpt_pkg;

  localparam int CMD_W    = 4;
  localparam int STATUS_W = 3;
  localparam int PCT_W    = 7;
  localparam int SPEED_W  = 22;
  localparam int TIME_W   = 32;
  localparam int FIELD_W  = 48;

  // bytes per KiB as a shift
  localparam int KIB_SHIFT = 10;

  localparam logic [SPEED_W-1:0] SPEED_START = 22'd1024;
  localparam logic [SPEED_W-1:0] SPEED_MIN   = 22'd10;
  localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
  localparam logic [TIME_W-1:0]  LEFT_MAX    = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0]  LEFT_OVER   = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 4'd0,
    CMD_KNOWN   = 4'd1,
    CMD_ADD     = 4'd2,
    CMD_SPEED   = 4'd3,
    CMD_SPENT   = 4'd4,
    CMD_SOURCE  = 4'd5,
    CMD_FINISH  = 4'd6,
    CMD_FAIL    = 4'd7,
    CMD_TIMEOUT = 4'd8,
    CMD_DUPE    = 4'd9,
    CMD_ABORT   = 4'd10
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS = 3'd0,
    ST_SUCCESS  = 3'd1,
    ST_FAILED   = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_DUPE     = 3'd4,
    ST_ABORTED  = 3'd5
  } status_t;

  // which quotient the current transfer still needs
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_PCT,
    JOB_EST_TOTAL,
    JOB_EST_LEFT
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic div_wb;
    logic direct_wb;
    logic out_load;
  } seq_ctl_t;

endpackage

FILE: rtl/core/tpt_div.sv
module tpt_div #(
  parameter int NUM_W = 55,
  parameter int DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step: shift in the next numerator bit, try the subtract
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/core/tpt_seq.sv
module tpt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              need_div,
  input  logic              div_done,
  input  logic              out_free,
  output tpt_pkg::seq_ctl_t ctl
);

  import tpt_pkg::*;

  seq_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = need_div ? S_RUN : S_FIN;
      end
      S_RUN: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: ctl.in_ready = 1'b1;
      S_PREP: begin
        ctl.div_start = need_div;
        ctl.direct_wb = !need_div;
      end
      S_RUN:  ctl.div_wb   = div_done;
      S_FIN:  ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/transfer_progress_tracker_top.sv
// Transfer progress tracker. One command comes in on the in_ channel
// (in_cmd, in_amount, in_rate_kib) with valid/ready; every command gives
// exactly one snapshot transfer on the out_ channel: status, percent, the
// shown/known/source sizes, speed, seconds left and seconds spent.
// Commands are handled one at a time. in_ready is high only while the
// sequencer is idle. A command that needs no quotient (speed, source size,
// finish, fail, timeout, dupe, abort, or a percent of 100 / an overrun
// estimate) goes from the prep step straight to the last step, which loads
// the snapshot, raises out_valid and returns the sequencer to idle. Start,
// time spent and growing sizes run the shared restoring divider, one quotient
// bit per cycle, between the prep and last steps. The divider is the only
// arithmetic loop.
// A finished snapshot sits in an output register, so the next command is
// accepted while out_ready is low; that command then waits in its last
// step until the snapshot is taken. Reset is synchronous: status in
// progress, source size 1, speed 1024 KiB/s, all other state zero, no
// output pending.
module transfer_progress_tracker_top #(
  parameter int SIZE_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tpt_pkg::CMD_W-1:0]          in_cmd,
  input  logic [tpt_pkg::FIELD_W-1:0]        in_amount,
  input  logic [tpt_pkg::SPEED_W-1:0]        in_rate_kib,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tpt_pkg::STATUS_W-1:0]       out_status,
  output logic [tpt_pkg::PCT_W-1:0]          out_percent,
  output logic [tpt_pkg::FIELD_W-1:0]        out_shown_bytes,
  output logic [tpt_pkg::FIELD_W-1:0]        out_known_bytes,
  output logic [tpt_pkg::FIELD_W-1:0]        out_total_bytes,
  output logic [tpt_pkg::SPEED_W-1:0]        out_speed_now,
  output logic signed [tpt_pkg::TIME_W-1:0]  out_seconds_left,
  output logic [tpt_pkg::TIME_W-1:0]         out_seconds_spent
);

  import tpt_pkg::*;

  localparam int SW     = SIZE_BITS;
  localparam int DIV_DW = (SIZE_BITS > SPEED_W) ? SIZE_BITS : SPEED_W;
  localparam int DIV_NW = DIV_DW + PCT_W;

  seq_ctl_t ctl;
  logic     accept;
  logic     need_div;
  logic     out_free;
  logic     div_done;

  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_quo;

  status_t            status_r, status_nxt;
  logic [SW-1:0]      total_r, total_nxt;
  logic [SW-1:0]      known_r, known_nxt;
  logic [SW-1:0]      shown_r, shown_nxt;
  logic [SW-1:0]      fill_r, fill_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [PCT_W-1:0]   percent_r, percent_nxt;
  logic [TIME_W-1:0]  left_r, left_nxt;
  logic [TIME_W-1:0]  spent_r, spent_nxt;
  job_t               job_r, job_nxt;

  logic [SW-1:0]      amt;
  logic [SW:0]        fill_sum;
  logic [SW-1:0]      fill_sat;
  logic [SW-1:0]      pct_base;

  logic [DIV_NW+TIME_W-1:0] quo_ext;
  logic                     est_sat;
  logic [TIME_W-1:0]        est_val;

  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [PCT_W-1:0]   out_percent_r;
  logic [FIELD_W-1:0] out_shown_r;
  logic [FIELD_W-1:0] out_known_r;
  logic [FIELD_W-1:0] out_total_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [TIME_W-1:0]  out_left_r;
  logic [TIME_W-1:0]  out_spent_r;

  tpt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .need_div (need_div),
    .div_done (div_done),
    .out_free (out_free),
    .ctl      (ctl)
  );

  tpt_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready = ctl.in_ready;
  assign accept   = in_valid && ctl.in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign amt      = SW'(in_amount);
  assign fill_sum = {1'b0, fill_r} + {1'b0, amt};
  assign fill_sat = fill_sum[SW] ? {SW{1'b1}} : fill_sum[SW-1:0];

  // quotient setup, combinational from the settled state registers
  always_comb begin
    need_div = 1'b0;
    pct_base = shown_r;
    div_num  = '0;
    div_den  = DIV_DW'(speed_r);
    unique case (job_r)
      JOB_NONE: need_div = 1'b0;
      JOB_PCT: begin
        need_div = shown_r < total_r;
        // 100 * shown as 64 + 32 + 4
        div_num  = (DIV_NW'(pct_base) << 6) + (DIV_NW'(pct_base) << 5)
                 + (DIV_NW'(pct_base) << 2);
        div_den  = DIV_DW'(total_r);
      end
      JOB_EST_TOTAL: begin
        need_div = 1'b1;
        div_num  = DIV_NW'(total_r >> KIB_SHIFT);
      end
      JOB_EST_LEFT: begin
        need_div = total_r > shown_r;
        div_num  = DIV_NW'((total_r - shown_r) >> KIB_SHIFT);
      end
      default: need_div = 1'b0;
    endcase
  end

  // a zero speed divides to all ones and lands in the saturation
  assign quo_ext = {{TIME_W{1'b0}}, div_quo};
  assign est_sat = |quo_ext[DIV_NW+TIME_W-1:TIME_W-1];
  assign est_val = est_sat ? LEFT_MAX : quo_ext[TIME_W-1:0];

  always_comb begin
    status_nxt  = status_r;
    total_nxt   = total_r;
    known_nxt   = known_r;
    shown_nxt   = shown_r;
    fill_nxt    = fill_r;
    speed_nxt   = speed_r;
    percent_nxt = percent_r;
    left_nxt    = left_r;
    spent_nxt   = spent_r;
    job_nxt     = job_r;

    if (accept) begin
      job_nxt = JOB_NONE;
      unique case (in_cmd)
        CMD_START: begin
          status_nxt  = ST_PROGRESS;
          total_nxt   = (amt != '0) ? amt : SW'(1);
          known_nxt   = '0;
          shown_nxt   = '0;
          fill_nxt    = '0;
          speed_nxt   = (in_rate_kib != '0) ? in_rate_kib : SPEED_START;
          percent_nxt = '0;
          spent_nxt   = '0;
          job_nxt     = JOB_EST_TOTAL;
        end
        CMD_KNOWN: begin
          known_nxt = amt;
          fill_nxt  = amt;
          if (amt > total_r) begin
            total_nxt = amt;
          end
          if (shown_r < amt) begin
            shown_nxt = amt;
            job_nxt   = JOB_PCT;
          end
        end
        CMD_ADD: begin
          if (fill_r < shown_r) begin
            fill_nxt = fill_sat;
            if (fill_sat > shown_r) begin
              shown_nxt = fill_sat;
              job_nxt   = JOB_PCT;
            end
          end else if (amt <= total_r && shown_r <= total_r - amt) begin
            shown_nxt = shown_r + amt;
            fill_nxt  = shown_r + amt;
            job_nxt   = JOB_PCT;
          end
        end
        CMD_SPEED: begin
          speed_nxt = (in_rate_kib != '0) ? in_rate_kib : SPEED_MIN;
        end
        CMD_SPENT: begin
          spent_nxt = in_amount[TIME_W-1:0];
          job_nxt   = JOB_EST_LEFT;
        end
        CMD_SOURCE: begin
          total_nxt = (amt != '0) ? amt : SW'(1);
        end
        CMD_FINISH: begin
          status_nxt  = ST_SUCCESS;
          percent_nxt = PCT_FULL;
          shown_nxt   = known_r;
          left_nxt    = '0;
        end
        CMD_FAIL, CMD_DUPE: begin
          // aborted is sticky
          if (status_r != ST_ABORTED) begin
            status_nxt  = (in_cmd == CMD_FAIL) ? ST_FAILED : ST_DUPE;
            known_nxt   = '0;
            shown_nxt   = '0;
            percent_nxt = '0;
            speed_nxt   = '0;
          end
          left_nxt = '0;
        end
        CMD_TIMEOUT: begin
          if (status_r != ST_ABORTED) begin
            status_nxt = ST_TIMEOUT;
          end
          left_nxt = '0;
        end
        CMD_ABORT: begin
          status_nxt = ST_ABORTED;
        end
        default: begin
        end
      endcase
    end

    if (ctl.direct_wb) begin
      unique case (job_r)
        JOB_PCT:      percent_nxt = PCT_FULL;
        JOB_EST_LEFT: left_nxt    = LEFT_OVER;
        JOB_NONE, JOB_EST_TOTAL: begin
        end
        default: begin
        end
      endcase
    end

    if (ctl.div_wb) begin
      if (job_r == JOB_PCT) begin
        percent_nxt = div_quo[PCT_W-1:0];
      end else begin
        left_nxt = est_val;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_PROGRESS;
      total_r     <= SW'(1);
      known_r     <= '0;
      shown_r     <= '0;
      fill_r      <= '0;
      speed_r     <= SPEED_START;
      percent_r   <= '0;
      left_r      <= '0;
      spent_r     <= '0;
      job_r       <= JOB_NONE;
      out_valid_r <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      total_r     <= total_nxt;
      known_r     <= known_nxt;
      shown_r     <= shown_nxt;
      fill_r      <= fill_nxt;
      speed_r     <= speed_nxt;
      percent_r   <= percent_nxt;
      left_r      <= left_nxt;
      spent_r     <= spent_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r  <= status_r;
      out_percent_r <= percent_r;
      out_shown_r   <= FIELD_W'(shown_r);
      out_known_r   <= FIELD_W'(known_r);
      out_total_r   <= FIELD_W'(total_r);
      out_speed_r   <= speed_r;
      out_left_r    <= left_r;
      out_spent_r   <= spent_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_percent       = out_percent_r;
  assign out_shown_bytes   = out_shown_r;
  assign out_known_bytes   = out_known_r;
  assign out_total_bytes   = out_total_r;
  assign out_speed_now     = out_speed_r;
  assign out_seconds_left  = $signed(out_left_r);
  assign out_seconds_spent = out_spent_r;

endmodule

FILE: rtl/core/tpt_checker.sv
module tpt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tpt_pkg::STATUS_W-1:0]       out_status,
  input logic [tpt_pkg::PCT_W-1:0]          out_percent,
  input logic [tpt_pkg::FIELD_W-1:0]        out_shown_bytes,
  input logic [tpt_pkg::FIELD_W-1:0]        out_known_bytes,
  input logic [tpt_pkg::FIELD_W-1:0]        out_total_bytes,
  input logic [tpt_pkg::SPEED_W-1:0]        out_speed_now,
  input logic signed [tpt_pkg::TIME_W-1:0]  out_seconds_left,
  input logic [tpt_pkg::TIME_W-1:0]         out_seconds_spent
);

  import tpt_pkg::*;

  // a stalled snapshot holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_percent) && $stable(out_shown_bytes)
      && $stable(out_known_bytes) && $stable(out_total_bytes)
      && $stable(out_speed_now) && $stable(out_seconds_left)
      && $stable(out_seconds_spent))
    else $error("snapshot changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  a_pct_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_percent <= PCT_FULL)
    else $error("percent above 100");

  // the source size never reads as zero
  a_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_bytes != '0)
    else $error("source size is zero");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind transfer_progress_tracker_top tpt_checker u_tpt_checker (.*);

FILE: verif/tracker_snapshot_checker.sv
module tracker_snapshot_checker #(
  parameter int SIZE_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [tpt_pkg::CMD_W-1:0]          in_cmd,
  input  logic [tpt_pkg::FIELD_W-1:0]        in_amount,
  input  logic [tpt_pkg::SPEED_W-1:0]        in_rate_kib,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [tpt_pkg::STATUS_W-1:0]       out_status,
  input  logic [tpt_pkg::PCT_W-1:0]          out_percent,
  input  logic [tpt_pkg::FIELD_W-1:0]        out_shown_bytes,
  input  logic [tpt_pkg::FIELD_W-1:0]        out_known_bytes,
  input  logic [tpt_pkg::FIELD_W-1:0]        out_total_bytes,
  input  logic [tpt_pkg::SPEED_W-1:0]        out_speed_now,
  input  logic signed [tpt_pkg::TIME_W-1:0]  out_seconds_left,
  input  logic [tpt_pkg::TIME_W-1:0]         out_seconds_spent,
  output int                                 errors,
  output int                                 pending
);

  import tpt_pkg::*;

  localparam logic [63:0] SIZE_MASK = (SIZE_BITS >= 64) ? '1 : ((64'd1 << SIZE_BITS) - 64'd1);

  typedef struct {
    status_t             status;
    logic [PCT_W-1:0]    pct;
    logic [FIELD_W-1:0]  shown;
    logic [FIELD_W-1:0]  known;
    logic [FIELD_W-1:0]  total;
    logic [SPEED_W-1:0]  speed;
    logic [TIME_W-1:0]   left;
    logic [TIME_W-1:0]   spent;
  } snapshot_t;

  // tracker state as the block should hold it
  status_t             trk_status;
  logic [63:0]         src_size;
  logic [63:0]         known_size;
  logic [63:0]         shown_size;
  logic [63:0]         fill_size;
  logic [SPEED_W-1:0]  speed_kib;
  logic [PCT_W-1:0]    pct_now;
  logic [TIME_W-1:0]   secs_left;
  logic [TIME_W-1:0]   secs_spent;

  snapshot_t snapshots_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [PCT_W-1:0] pct_of(input logic [63:0] shown,
                                               input logic [63:0] total);
    logic [63:0] q;
    if (shown >= total) return PCT_FULL;
    q = (shown * 64'd100) / total;
    return (q > 64'd100) ? PCT_FULL : q[PCT_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] eta_secs(input logic [63:0] bytes);
    logic [63:0] div;
    logic [63:0] q;
    div = {42'b0, speed_kib} << KIB_SHIFT;
    if (div == 64'd0) return LEFT_MAX;
    q = bytes / div;
    return (q > {32'b0, LEFT_MAX}) ? LEFT_MAX : q[TIME_W-1:0];
  endfunction

  function automatic snapshot_t apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [FIELD_W-1:0] amount_raw,
                                              input logic [SPEED_W-1:0] rate);
    logic [63:0] amt;
    logic [63:0] sum;
    snapshot_t   snap;
    amt = {16'b0, amount_raw} & SIZE_MASK;
    case (cmd_t'(cmd))
      CMD_START: begin
        trk_status = ST_PROGRESS;
        src_size   = (amt != 0) ? amt : 64'd1;
        known_size = 0;
        shown_size = 0;
        fill_size  = 0;
        speed_kib  = (rate != 0) ? rate : SPEED_START;
        pct_now    = 0;
        secs_spent = 0;
        secs_left  = eta_secs(src_size);
      end
      CMD_KNOWN: begin
        known_size = amt;
        if (known_size > src_size) src_size = known_size;
        if (shown_size < known_size) begin
          shown_size = known_size;
          pct_now    = pct_of(shown_size, src_size);
        end
        fill_size = known_size;
      end
      CMD_ADD: begin
        if (fill_size < shown_size) begin
          // interpolation catches up from the last real size, saturating
          sum       = fill_size + amt;
          fill_size = (sum > SIZE_MASK) ? SIZE_MASK : sum;
          if (fill_size > shown_size) begin
            shown_size = fill_size;
            pct_now    = pct_of(shown_size, src_size);
          end
        end else if (amt <= src_size && shown_size <= src_size - amt) begin
          shown_size = shown_size + amt;
          fill_size  = shown_size;
          pct_now    = pct_of(shown_size, src_size);
        end
      end
      CMD_SPEED: speed_kib = (rate != 0) ? rate : SPEED_MIN;
      CMD_SPENT: begin
        secs_spent = amount_raw[TIME_W-1:0];
        secs_left  = (src_size > shown_size) ? eta_secs(src_size - shown_size) : LEFT_OVER;
      end
      CMD_SOURCE: src_size = (amt != 0) ? amt : 64'd1;
      CMD_FINISH: begin
        trk_status = ST_SUCCESS;
        pct_now    = PCT_FULL;
        shown_size = known_size;
        secs_left  = 0;
      end
      CMD_FAIL, CMD_DUPE: begin
        // aborted status is sticky
        if (trk_status != ST_ABORTED) begin
          trk_status = (cmd_t'(cmd) == CMD_FAIL) ? ST_FAILED : ST_DUPE;
          known_size = 0;
          shown_size = 0;
          pct_now    = 0;
          speed_kib  = 0;
        end
        secs_left = 0;
      end
      CMD_TIMEOUT: begin
        if (trk_status != ST_ABORTED) trk_status = ST_TIMEOUT;
        secs_left = 0;
      end
      CMD_ABORT: trk_status = ST_ABORTED;
      default: ;
    endcase
    snap.status = trk_status;
    snap.pct    = pct_now;
    snap.shown  = shown_size[FIELD_W-1:0];
    snap.known  = known_size[FIELD_W-1:0];
    snap.total  = src_size[FIELD_W-1:0];
    snap.speed  = speed_kib;
    snap.left   = secs_left;
    snap.spent  = secs_spent;
    return snap;
  endfunction

  always @(posedge clk) begin
    snapshot_t want;
    if (!rst_n) begin
      trk_status = ST_PROGRESS;
      src_size   = 64'd1;
      known_size = 0;
      shown_size = 0;
      fill_size  = 0;
      speed_kib  = SPEED_START;
      pct_now    = 0;
      secs_left  = 0;
      secs_spent = 0;
      snapshots_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (snapshots_due.size() == 0) begin
          flag_mismatch("unexpected snapshot, status", 64'(out_status), 64'd0);
        end else begin
          want = snapshots_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_percent !== want.pct)
            flag_mismatch("percent", 64'(out_percent), 64'(want.pct));
          if (out_shown_bytes !== want.shown)
            flag_mismatch("shown_bytes", 64'(out_shown_bytes), 64'(want.shown));
          if (out_known_bytes !== want.known)
            flag_mismatch("known_bytes", 64'(out_known_bytes), 64'(want.known));
          if (out_total_bytes !== want.total)
            flag_mismatch("total_bytes", 64'(out_total_bytes), 64'(want.total));
          if (out_speed_now !== want.speed)
            flag_mismatch("speed_now", 64'(out_speed_now), 64'(want.speed));
          if (out_seconds_left !== want.left)
            flag_mismatch("seconds_left", 64'(unsigned'(out_seconds_left)), 64'(want.left));
          if (out_seconds_spent !== want.spent)
            flag_mismatch("seconds_spent", 64'(out_seconds_spent), 64'(want.spent));
        end
      end
      // append at the tail, oldest snapshot stays at the front
      if (in_valid && in_ready)
        snapshots_due.insert(snapshots_due.size(),
                             apply_command(in_cmd, in_amount, in_rate_kib));
    end
    pending = snapshots_due.size();
  end

endmodule

FILE: verif/transfer_progress_tracker_top_test.sv
module transfer_progress_tracker_top_test;
  import tpt_pkg::*;

  localparam int SIZE_BITS    = 48;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [FIELD_W-1:0] FIELD_MAX    = '1;
  localparam logic [SPEED_W-1:0] RATE_MAX     = '1;
  localparam logic [CMD_W-1:0]   CMD_SPARE_LO = 4'd11;
  localparam logic [CMD_W-1:0]   CMD_SPARE_HI = 4'd15;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_cmd;
  logic [FIELD_W-1:0]        in_amount;
  logic [SPEED_W-1:0]        in_rate_kib;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       out_status;
  logic [PCT_W-1:0]          out_percent;
  logic [FIELD_W-1:0]        out_shown_bytes;
  logic [FIELD_W-1:0]        out_known_bytes;
  logic [FIELD_W-1:0]        out_total_bytes;
  logic [SPEED_W-1:0]        out_speed_now;
  logic signed [TIME_W-1:0]  out_seconds_left;
  logic [TIME_W-1:0]         out_seconds_spent;

  int          errors;
  int          pending;
  int          sent;
  int          burst_left;
  int unsigned cycles;

  transfer_progress_tracker_top #(.SIZE_BITS(SIZE_BITS)) dut (.*);

  tracker_snapshot_checker #(.SIZE_BITS(SIZE_BITS)) snap_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls follow a rotating pattern that changes now and then
  initial begin
    logic [15:0] pat;
    int          hold;
    out_ready = 1'b0;
    pat       = 16'hFFFF;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        case ($urandom_range(0, 3))
          0:       pat = 16'hFFFF;
          1:       pat = 16'($urandom);
          2:       pat = 16'h0001 << $urandom_range(0, 15);
          default: pat = 16'h3333;
        endcase
        if (pat == 16'h0) pat = 16'h0001;
        hold = $urandom_range(40, 400);
      end
      hold--;
      out_ready <= pat[0];
      pat = {pat[0], pat[15:1]};
    end
  end

  function automatic logic [FIELD_W-1:0] rand_size(input logic [63:0] hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return FIELD_W'(r % (hi + 64'd1));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_total();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FIELD_MAX;
      2:       return rand_size(64'(FIELD_MAX));
      default: return rand_size(64'd1 << $urandom_range(4, 40));
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RATE_MAX;
      2:       return SPEED_W'($urandom);
      default: return SPEED_W'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] amt,
                          input logic [SPEED_W-1:0] rate);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_amount   <= amt;
    in_rate_kib <= rate;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] seq_total;
    int                 pick;
    int                 goal;
    in_valid    = 1'b0;
    in_cmd      = CMD_START;
    in_amount   = '0;
    in_rate_kib = '0;
    sent        = 0;
    burst_left  = 0;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    push_cmd(CMD_START, '0, '0);
    push_cmd(CMD_SPENT, FIELD_MAX, '0);
    push_cmd(CMD_START, FIELD_MAX, 22'd1);
    push_cmd(CMD_START, 48'd1000, RATE_MAX);
    push_cmd(CMD_KNOWN, 48'd400, '0);
    push_cmd(CMD_ADD, 48'd300, '0);
    push_cmd(CMD_KNOWN, 48'd100, '0);
    // fill below shown, then a huge add saturates the sizes
    push_cmd(CMD_ADD, FIELD_MAX, '0);
    push_cmd(CMD_SPENT, 48'd5, '0);
    push_cmd(CMD_SOURCE, '0, '0);
    push_cmd(CMD_SPEED, '0, '0);
    push_cmd(CMD_SPEED, '0, RATE_MAX);
    push_cmd(CMD_ADD, '0, '0);
    push_cmd(CMD_FINISH, '0, '0);
    push_cmd(CMD_START, 48'd12345, 22'd7);
    push_cmd(CMD_FAIL, '0, '0);
    // speed is zero after a failure
    push_cmd(CMD_SPENT, 48'd1, '0);
    push_cmd(CMD_DUPE, '0, '0);
    push_cmd(CMD_TIMEOUT, '0, '0);
    push_cmd(CMD_ABORT, '0, '0);
    push_cmd(CMD_FAIL, '0, '0);
    push_cmd(CMD_TIMEOUT, '0, '0);
    push_cmd(CMD_DUPE, '0, '0);
    push_cmd(CMD_FINISH, '0, '0);
    push_cmd(CMD_SPARE_LO, FIELD_MAX, RATE_MAX);
    push_cmd(CMD_SPARE_HI, '0, '0);

    // random transfers: start, progress updates, usually an ending
    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      seq_total = pick_total();
      push_cmd(CMD_START, seq_total, pick_rate());
      if (seq_total == '0) seq_total = 48'd1;
      repeat ($urandom_range(2, 14)) begin
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
          push_cmd(CMD_KNOWN, rand_size(64'(seq_total) + 64'(seq_total >> 3)),
                   SPEED_W'($urandom));
        end else if (pick < 11) begin
          push_cmd(CMD_ADD, rand_size(64'(seq_total >> 2) + 64'd1), SPEED_W'($urandom));
        end else if (pick < 13) begin
          push_cmd(CMD_SPENT,
                   ($urandom_range(0, 3) == 0) ? rand_size(64'(FIELD_MAX)) : 48'($urandom),
                   SPEED_W'($urandom));
        end else if (pick < 15) begin
          push_cmd(CMD_SPEED, rand_size(64'(FIELD_MAX)), pick_rate());
        end else if (pick == 15) begin
          seq_total = pick_total();
          push_cmd(CMD_SOURCE, seq_total, SPEED_W'($urandom));
          if (seq_total == '0) seq_total = 48'd1;
        end else if (pick == 16) begin
          push_cmd(CMD_W'($urandom_range(0, 15)), rand_size(64'(FIELD_MAX)),
                   SPEED_W'($urandom));
        end else if (pick == 17) begin
          push_cmd(CMD_FINISH, rand_size(64'(FIELD_MAX)), SPEED_W'($urandom));
        end else begin
          push_cmd(CMD_ADD, rand_size(64'd4096), SPEED_W'($urandom));
        end
      end
      case ($urandom_range(0, 6))
        0: push_cmd(CMD_FINISH, '0, '0);
        1: push_cmd(CMD_FAIL, '0, '0);
        2: push_cmd(CMD_TIMEOUT, '0, '0);
        3: push_cmd(CMD_DUPE, '0, '0);
        4: begin
          push_cmd(CMD_ABORT, '0, '0);
          push_cmd(CMD_W'($urandom_range(CMD_FINISH, CMD_DUPE)), '0, '0);
        end
        5: ;
        default: begin
          push_cmd(CMD_ABORT, '0, '0);
          push_cmd(CMD_SPENT, 48'($urandom), '0);
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
